// ===== rtl/ucrb_pkg.sv =====
// Shared types and constants for the UART ring buffer engine.
package ucrb_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RTS_STOP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTS_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_BURST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REBOOT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK     = 3'd4;

  localparam logic [2:0] CMD_LINE_RX   = 3'd0;
  localparam logic [2:0] CMD_HOST_RD   = 3'd1;
  localparam logic [2:0] CMD_HOST_WR   = 3'd2;
  localparam logic [2:0] CMD_TX_READY  = 3'd3;
  localparam logic [2:0] CMD_MODEM     = 3'd4;

  localparam logic [7:0] RST_RTS_STOP  = 8'd192;
  localparam logic [7:0] RST_RTS_START = 8'd16;
  localparam logic [4:0] RST_TX_BURST  = 5'd16;
  localparam logic [7:0] RST_REBOOT    = 8'h1a;
  localparam logic [7:0] RST_BREAK     = 8'h03;

  localparam logic KIND_TX_BYTE = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [7:0] rts_stop_level;
    logic [7:0] rts_start_level;
    logic [4:0] tx_burst;
    logic [7:0] reboot_char;
    logic [7:0] break_char;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_out;
    logic       read_valid;
    logic       rejected;
    logic       rts_level;
    logic       reboot_request;
    logic       break_request;
    logic [7:0] rx_occupancy;
    logic [7:0] tx_occupancy;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_BRD,
    ST_BOUT,
    ST_STAT
  } state_t;

endpackage

// ===== rtl/ucrb_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface ucrb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data;
  logic       thr_empty;
  logic       cts;
  logic       cts_changed;

  modport source (output valid, command, data, thr_empty, cts, cts_changed, input ready);
  modport sink   (input valid, command, data, thr_empty, cts, cts_changed, output ready);
endinterface

interface ucrb_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_out;
  logic       read_valid;
  logic       rejected;
  logic       rts_level;
  logic       reboot_request;
  logic       break_request;
  logic [7:0] rx_occupancy;
  logic [7:0] tx_occupancy;
  logic       last;

  modport source (output valid, kind, byte_out, read_valid, rejected, rts_level,
                  reboot_request, break_request, rx_occupancy, tx_occupancy, last,
                  input ready);
  modport sink   (input valid, kind, byte_out, read_valid, rejected, rts_level,
                  reboot_request, break_request, rx_occupancy, tx_occupancy, last,
                  output ready);
endinterface

// ===== rtl/ucrb_ram.sv =====
// Byte-wide ring memory, one write port and one registered read port.
module ucrb_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/ucrb_ctrl.sv =====
// Command sequencer: ring pointers, RTS/CTS flow control, bursts and result register.
module ucrb_ctrl #(
  parameter int BUFFER_DEPTH = 256,
  parameter int TX_BURST_MAX = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ucrb_pkg::cfg_t cfg,
  ucrb_in_if.sink       in_ch,
  ucrb_out_if.source    out_ch
);
  import ucrb_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH);
  localparam int BW = $clog2(TX_BURST_MAX + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(BUFFER_DEPTH - 1);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [7:0] sat8(input logic [CW-1:0] v);
    logic [CW+7:0] w;
    w = (CW+8)'(v);
    return (w > (CW+8)'(255)) ? 8'hff : w[7:0];
  endfunction

  state_t        state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [7:0]    data_r, data_nxt;
  logic          thre_r, thre_nxt;
  logic          cts_r, cts_nxt;
  logic          chg_r, chg_nxt;
  logic [PW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [PW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic [CW-1:0] rx_cnt_r, rx_cnt_nxt, tx_cnt_r, tx_cnt_nxt;
  logic          stopped_r, stopped_nxt;
  logic          rts_r, rts_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          rv_r, rv_nxt, rej_r, rej_nxt, rb_r, rb_nxt, br_r, br_nxt;
  logic [BW-1:0] left_r, left_nxt;
  logic          out_vld_r, out_vld_nxt;
  res_t          pay_r, pay_nxt;

  logic          rx_we, rx_re, tx_we, tx_re;
  logic [7:0]    rx_rdata, tx_rdata;
  logic          slot_free;
  logic [BW-1:0] burst_n;

  ucrb_ram #(.DEPTH(BUFFER_DEPTH)) u_rx_ram (
    .clk     (clk),
    .we      (rx_we),
    .waddr   (rx_wp_r),
    .wdata   (data_r),
    .re      (rx_re),
    .raddr   (rx_rp_r),
    .rdata_r (rx_rdata)
  );

  ucrb_ram #(.DEPTH(BUFFER_DEPTH)) u_tx_ram (
    .clk     (clk),
    .we      (tx_we),
    .waddr   (tx_wp_r),
    .wdata   (data_r),
    .re      (tx_re),
    .raddr   (tx_rp_r),
    .rdata_r (tx_rdata)
  );

  assign slot_free = !out_vld_r || out_ch.ready;
  assign burst_n   = ({3'b000, cfg.tx_burst} > 8'(TX_BURST_MAX)) ?
                     BW'(TX_BURST_MAX) : BW'(cfg.tx_burst);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    data_nxt    = data_r;
    thre_nxt    = thre_r;
    cts_nxt     = cts_r;
    chg_nxt     = chg_r;
    rx_wp_nxt   = rx_wp_r;
    rx_rp_nxt   = rx_rp_r;
    tx_wp_nxt   = tx_wp_r;
    tx_rp_nxt   = tx_rp_r;
    rx_cnt_nxt  = rx_cnt_r;
    tx_cnt_nxt  = tx_cnt_r;
    stopped_nxt = stopped_r;
    rts_nxt     = rts_r;
    byte_nxt    = byte_r;
    rv_nxt      = rv_r;
    rej_nxt     = rej_r;
    rb_nxt      = rb_r;
    br_nxt      = br_r;
    left_nxt    = left_r;
    pay_nxt     = pay_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          data_nxt  = in_ch.data;
          thre_nxt  = in_ch.thr_empty;
          cts_nxt   = in_ch.cts;
          chg_nxt   = in_ch.cts_changed;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        byte_nxt  = '0;
        rv_nxt    = 1'b0;
        rej_nxt   = 1'b0;
        rb_nxt    = 1'b0;
        br_nxt    = 1'b0;
        left_nxt  = burst_n;
        state_nxt = ST_STAT;
        unique case (cmd_r)
          CMD_LINE_RX: begin
            if (data_r == cfg.reboot_char) begin
              rb_nxt = 1'b1;
            end else if (data_r == cfg.break_char) begin
              br_nxt = 1'b1;
            end else if (rx_cnt_r < CNT_FULL) begin
              rx_we      = 1'b1;
              rx_wp_nxt  = ring_next(rx_wp_r);
              rx_cnt_nxt = rx_cnt_r + 1'b1;
            end
            if ((CW+8)'(rx_cnt_nxt) >= (CW+8)'(cfg.rts_stop_level)) begin
              rts_nxt = 1'b0;
            end
          end
          CMD_HOST_RD: begin
            if (rx_cnt_r == '0) begin
              rej_nxt = 1'b1;
            end else begin
              rx_re     = 1'b1;
              state_nxt = ST_RDWAIT;
            end
          end
          CMD_HOST_WR: begin
            if (tx_cnt_r >= CNT_FULL) begin
              rej_nxt = 1'b1;
            end else begin
              tx_we      = 1'b1;
              tx_wp_nxt  = ring_next(tx_wp_r);
              tx_cnt_nxt = tx_cnt_r + 1'b1;
              if (thre_r && !stopped_r) begin
                state_nxt = ST_BRD;
              end
            end
          end
          CMD_TX_READY: begin
            if (thre_r && !stopped_r) begin
              state_nxt = ST_BRD;
            end
          end
          CMD_MODEM: begin
            if (chg_r) begin
              if (!cts_r) begin
                stopped_nxt = 1'b1;
              end else begin
                stopped_nxt = 1'b0;
                if (thre_r) begin
                  state_nxt = ST_BRD;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_RDWAIT: begin
        byte_nxt   = rx_rdata;
        rv_nxt     = 1'b1;
        rx_rp_nxt  = ring_next(rx_rp_r);
        rx_cnt_nxt = rx_cnt_r - 1'b1;
        if ((CW+8)'(rx_cnt_nxt) < (CW+8)'(cfg.rts_start_level)) begin
          rts_nxt = 1'b1;
        end
        state_nxt = ST_STAT;
      end
      ST_BRD: begin
        if (left_r == '0 || tx_cnt_r == '0) begin
          state_nxt = ST_STAT;
        end else if (slot_free) begin
          tx_re      = 1'b1;
          tx_rp_nxt  = ring_next(tx_rp_r);
          tx_cnt_nxt = tx_cnt_r - 1'b1;
          left_nxt   = left_r - 1'b1;
          state_nxt  = ST_BOUT;
        end
      end
      ST_BOUT: begin
        pay_nxt.kind           = KIND_TX_BYTE;
        pay_nxt.byte_out       = tx_rdata;
        pay_nxt.read_valid     = 1'b0;
        pay_nxt.rejected       = 1'b0;
        pay_nxt.rts_level      = rts_r;
        pay_nxt.reboot_request = 1'b0;
        pay_nxt.break_request  = 1'b0;
        pay_nxt.rx_occupancy   = sat8(rx_cnt_r);
        pay_nxt.tx_occupancy   = sat8(tx_cnt_r);
        pay_nxt.last           = 1'b0;
        out_vld_nxt            = 1'b1;
        state_nxt              = ST_BRD;
      end
      ST_STAT: begin
        if (slot_free) begin
          pay_nxt.kind           = KIND_STATUS;
          pay_nxt.byte_out       = byte_r;
          pay_nxt.read_valid     = rv_r;
          pay_nxt.rejected       = rej_r;
          pay_nxt.rts_level      = rts_r;
          pay_nxt.reboot_request = rb_r;
          pay_nxt.break_request  = br_r;
          pay_nxt.rx_occupancy   = sat8(rx_cnt_r);
          pay_nxt.tx_occupancy   = sat8(tx_cnt_r);
          pay_nxt.last           = 1'b1;
          out_vld_nxt            = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rx_wp_r   <= PW'(1);
      rx_rp_r   <= PW'(1);
      tx_wp_r   <= PW'(1);
      tx_rp_r   <= PW'(1);
      rx_cnt_r  <= '0;
      tx_cnt_r  <= '0;
      stopped_r <= 1'b0;
      rts_r     <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rx_wp_r   <= rx_wp_nxt;
      rx_rp_r   <= rx_rp_nxt;
      tx_wp_r   <= tx_wp_nxt;
      tx_rp_r   <= tx_rp_nxt;
      rx_cnt_r  <= rx_cnt_nxt;
      tx_cnt_r  <= tx_cnt_nxt;
      stopped_r <= stopped_nxt;
      rts_r     <= rts_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    data_r <= data_nxt;
    thre_r <= thre_nxt;
    cts_r  <= cts_nxt;
    chg_r  <= chg_nxt;
    byte_r <= byte_nxt;
    rv_r   <= rv_nxt;
    rej_r  <= rej_nxt;
    rb_r   <= rb_nxt;
    br_r   <= br_nxt;
    left_r <= left_nxt;
    pay_r  <= pay_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.kind           = pay_r.kind;
  assign out_ch.byte_out       = pay_r.byte_out;
  assign out_ch.read_valid     = pay_r.read_valid;
  assign out_ch.rejected       = pay_r.rejected;
  assign out_ch.rts_level      = pay_r.rts_level;
  assign out_ch.reboot_request = pay_r.reboot_request;
  assign out_ch.break_request  = pay_r.break_request;
  assign out_ch.rx_occupancy   = pay_r.rx_occupancy;
  assign out_ch.tx_occupancy   = pay_r.tx_occupancy;
  assign out_ch.last           = pay_r.last;

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_EXEC))
    else $error("accepted item did not start execution");

  a_burst_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BOUT) |=> (out_vld_r && pay_r.kind == KIND_TX_BYTE))
    else $error("burst byte not loaded into result register");

  a_status_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STAT && slot_free) |=>
      (state_r == ST_IDLE && out_vld_r && pay_r.last))
    else $error("status item not loaded on closing step");

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_cnt_r <= CNT_FULL) && (tx_cnt_r <= CNT_FULL))
    else $error("ring occupancy beyond capacity");
`endif

endmodule

// ===== rtl/uart_ring_buffers_rts_cts_flow.sv =====
// Top level: configuration registers around the ring buffer sequencer.
// Sequence: an accepted item passes EXEC (then RDWAIT for a host read) to STAT,
// which loads the status item once the result register is free. A burst sends each
// byte via BRD (ring memory read) and BOUT before STAT; only IDLE accepts new items.
// Reset (synchronous, active low): rings empty, RTS high, CTS not stopped,
// registers at defaults; ring memories are not cleared.
module uart_ring_buffers_rts_cts_flow #(
  parameter int BUFFER_DEPTH = 256,
  parameter int TX_BURST_MAX = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ucrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  ucrb_in_if.sink                        in_ch,
  ucrb_out_if.source                     out_ch
);
  import ucrb_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RTS_STOP:  cfg_nxt.rts_stop_level  = cfg_wdata;
        CFG_RTS_START: cfg_nxt.rts_start_level = cfg_wdata;
        CFG_TX_BURST:  cfg_nxt.tx_burst        = cfg_wdata[4:0];
        CFG_REBOOT:    cfg_nxt.reboot_char     = cfg_wdata;
        CFG_BREAK:     cfg_nxt.break_char      = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rts_stop_level  <= RST_RTS_STOP;
      cfg_r.rts_start_level <= RST_RTS_START;
      cfg_r.tx_burst        <= RST_TX_BURST;
      cfg_r.reboot_char     <= RST_REBOOT;
      cfg_r.break_char      <= RST_BREAK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ucrb_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .TX_BURST_MAX (TX_BURST_MAX)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
